// File: rtl/assert_macros.svh
// Assertion macros shared by the bisection square root RTL.
// Include with the bare file name; each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is low.
`define ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bsr: assertion failed");

// Same-cycle implication, off while reset is low.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bsr: implication failed");

`endif

// File: rtl/bsr_pkg.sv
// Package for the bisection square root core: widths, sign type, helpers.
// No dependencies; imported by every module of the core.
`default_nettype none

package bsr_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int PROD_W        = 2 * VALUE_WIDTH;
    localparam int FIELD_W       = 32;
    localparam int TOL_W         = 32;
    localparam int STEP_W        = 6;
    localparam int CMP_W         = (VALUE_WIDTH > TOL_W) ? VALUE_WIDTH : TOL_W;
    localparam int MAX_STEPS     = VALUE_WIDTH + 8;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(16);

    typedef logic [VALUE_WIDTH-1:0] value_t;

    // Sign of x*x - radicand: gt means positive, eq means exact root.
    typedef struct packed {
        logic gt;
        logic eq;
    } fsign_t;

    function automatic value_t midpoint(value_t x, value_t y);
        logic [VALUE_WIDTH:0] sum;
        sum = {1'b0, x} + {1'b0, y};
        return sum[VALUE_WIDTH:1];
    endfunction

    function automatic logic within_tol(value_t x, value_t y, logic [TOL_W-1:0] tol);
        value_t d;
        d = (x > y) ? x - y : y - x;
        return CMP_W'(d) <= CMP_W'(tol);
    endfunction

endpackage

`default_nettype wire

// File: rtl/bisection_square_root_core.sv
// Bisection square root core: after accept, each limit is squared and compared, then
// each step squares and compares the midpoint; a bad bracket goes straight to the result.
// One word at a time: the next word is taken only once the result is in the output
// register; s_tready is high only while the sequencer, with its shared squarer, is idle.
// Reset (aresetn low, synchronous) empties the block and sets tolerance to 16.
`default_nettype none

module bisection_square_root_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] radicand, [63:32] first_limit, [95:64] second_limit
    input  wire logic [95:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] root, [37:32] step_count, [39:38] zero
    output logic [39:0]      m_tdata,
    // [0] status
    output logic [0:0]       m_tuser
);
    import bsr_pkg::*;

    logic [TOL_W-1:0]  tol_reg, tol_next;
    value_t            root;
    logic [STEP_W-1:0] step_count;
    logic              status;

    // A zero tolerance would never end the loop: store it as one.
    always_comb begin
        tol_next = tol_reg;
        if (cfg_we) begin
            tol_next = (cfg_wdata == '0) ? TOL_W'(1) : TOL_W'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else begin
            tol_reg <= tol_next;
        end
    end

    bsr_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .radicand     (VALUE_WIDTH'(s_tdata[31:0])),
        .first_limit  (VALUE_WIDTH'(s_tdata[63:32])),
        .second_limit (VALUE_WIDTH'(s_tdata[95:64])),
        .tol          (tol_reg),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .root         (root),
        .step_count   (step_count),
        .status       (status)
    );

    assign m_tdata = {2'b00, step_count, FIELD_W'(root)};
    assign m_tuser = status;

endmodule

`default_nettype wire

// File: rtl/bsr_square_unit.sv
// Shared squaring unit: registers x*x and compares it with the scaled radicand.
// Depends on bsr_pkg.
`default_nettype none

module bsr_square_unit (
    input  wire logic             aclk,
    input  wire logic             load,
    input  wire bsr_pkg::value_t  x,
    input  wire bsr_pkg::value_t  radicand,
    output bsr_pkg::fsign_t       sign
);
    import bsr_pkg::*;

    logic [PROD_W-1:0] sq_reg;
    logic [PROD_W-1:0] sq_next;
    logic [PROD_W-1:0] rad_scaled;

    assign sq_next    = PROD_W'(x) * PROD_W'(x);
    assign rad_scaled = PROD_W'(radicand) << FRACTION_BITS;

    always_ff @(posedge aclk) begin
        if (load) begin
            sq_reg <= sq_next;
        end
    end

    assign sign.gt = sq_reg > rad_scaled;
    assign sign.eq = sq_reg == rad_scaled;

endmodule

`default_nettype wire

// File: rtl/bsr_seq.sv
// Sequencer and bracket registers of the bisection square root core.
// Depends on bsr_pkg, bsr_square_unit and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bsr_seq (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire bsr_pkg::value_t               radicand,
    input  wire bsr_pkg::value_t               first_limit,
    input  wire bsr_pkg::value_t               second_limit,
    input  wire logic [bsr_pkg::TOL_W-1:0]     tol,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output bsr_pkg::value_t                    root,
    output logic [bsr_pkg::STEP_W-1:0]         step_count,
    output logic                               status
);
    import bsr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FA_SQ  = 3'd1;
    localparam logic [2:0] S_FA_CMP = 3'd2;
    localparam logic [2:0] S_FB_SQ  = 3'd3;
    localparam logic [2:0] S_FB_CMP = 3'd4;
    localparam logic [2:0] S_SQ     = 3'd5;
    localparam logic [2:0] S_CMP    = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0]        state_reg, state_next;
    value_t            r_reg, r_next;
    value_t            a_reg, a_next;
    value_t            b_reg, b_next;
    value_t            mid_reg, mid_next;
    value_t            mid_a_reg, mid_a_next;
    value_t            mid_b_reg, mid_b_next;
    logic              done_a_reg, done_a_next;
    logic              done_b_reg, done_b_next;
    logic              sa_pos_reg, sa_pos_next;
    logic              sa_neg_reg, sa_neg_next;
    logic              err_reg, err_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic              m_valid_reg, m_valid_next;
    value_t            m_root_reg, m_root_next;
    logic [STEP_W-1:0] m_steps_reg, m_steps_next;
    logic              m_status_reg, m_status_next;

    logic   sq_load;
    value_t sq_x;
    fsign_t fs;
    logic   f_neg;
    logic   repl_a;

    assign sq_load = (state_reg == S_FA_SQ) || (state_reg == S_FB_SQ) || (state_reg == S_SQ);

    always_comb begin
        case (state_reg)
            S_FA_SQ: sq_x = a_reg;
            S_FB_SQ: sq_x = b_reg;
            default: sq_x = mid_reg;
        endcase
    end

    bsr_square_unit u_square (
        .aclk     (aclk),
        .load     (sq_load),
        .x        (sq_x),
        .radicand (r_reg),
        .sign     (fs)
    );

    assign f_neg  = !fs.gt && !fs.eq;
    // Replace the first limit only on a strict sign match; a zero moves the second.
    assign repl_a = (sa_pos_reg && fs.gt) || (sa_neg_reg && f_neg);

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        r_next        = r_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        mid_next      = mid_reg;
        mid_a_next    = mid_a_reg;
        mid_b_next    = mid_b_reg;
        done_a_next   = done_a_reg;
        done_b_next   = done_b_reg;
        sa_pos_next   = sa_pos_reg;
        sa_neg_next   = sa_neg_reg;
        err_next      = err_reg;
        steps_next    = steps_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_root_next   = m_root_reg;
        m_steps_next  = m_steps_reg;
        m_status_next = m_status_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    r_next     = radicand;
                    a_next     = first_limit;
                    b_next     = second_limit;
                    state_next = S_FA_SQ;
                end
            end
            S_FA_SQ: begin
                state_next = S_FA_CMP;
            end
            S_FA_CMP: begin
                sa_pos_next = fs.gt;
                sa_neg_next = f_neg;
                state_next  = S_FB_SQ;
            end
            S_FB_SQ: begin
                state_next = S_FB_CMP;
            end
            S_FB_CMP: begin
                mid_next   = midpoint(a_reg, b_reg);
                steps_next = '0;
                if ((sa_pos_reg && f_neg) || (sa_neg_reg && fs.gt)) begin
                    err_next   = 1'b0;
                    state_next = S_SQ;
                end else begin
                    err_next   = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_SQ: begin
                // Prepare both outcomes while the square is formed.
                mid_a_next  = midpoint(mid_reg, b_reg);
                mid_b_next  = midpoint(a_reg, mid_reg);
                done_a_next = within_tol(mid_reg, b_reg, tol);
                done_b_next = within_tol(a_reg, mid_reg, tol);
                state_next  = S_CMP;
            end
            S_CMP: begin
                steps_next = steps_reg + STEP_W'(1);
                if (repl_a) begin
                    a_next   = mid_reg;
                    mid_next = mid_a_reg;
                end else begin
                    b_next   = mid_reg;
                    mid_next = mid_b_reg;
                end
                if (repl_a ? done_a_reg : done_b_reg) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_SQ;
                end
            end
            S_FIN: begin
                // Hold until the output word is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_root_next   = err_reg ? '0 : mid_reg;
                    m_steps_next  = steps_reg;
                    m_status_next = err_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            steps_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            steps_reg   <= steps_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg        <= r_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        mid_reg      <= mid_next;
        mid_a_reg    <= mid_a_next;
        mid_b_reg    <= mid_b_next;
        done_a_reg   <= done_a_next;
        done_b_reg   <= done_b_next;
        sa_pos_reg   <= sa_pos_next;
        sa_neg_reg   <= sa_neg_next;
        err_reg      <= err_next;
        m_root_reg   <= m_root_next;
        m_steps_reg  <= m_steps_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid    = m_valid_reg;
    assign root       = m_root_reg;
    assign step_count = m_steps_reg;
    assign status     = m_status_reg;

    `ASSERT_IMPLIES(a_err_clears_fields, aclk, aresetn, m_valid_reg && m_status_reg, (m_steps_reg == '0) && (m_root_reg == '0))
    `ASSERT_RST(a_step_bound, aclk, aresetn, (steps_reg <= STEP_W'(MAX_STEPS)))
    `ASSERT_RST(a_accept_starts, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == S_FA_SQ))
    `ASSERT_RST(a_fin_waits, aclk, aresetn, (state_reg == S_FIN && m_valid_reg && !m_ready) |=> (state_reg == S_FIN))

endmodule

`default_nettype wire
